[hw/rtl/scpa_pkg.sv]
// Shared types, codes and defaults for the size class pool allocator.
// No dependencies; every other file of the block imports this package.
package scpa_pkg;

  // Default geometry, handed down from the top level as parameters
  localparam int unsigned BLOCKS_PER_CLASS_DEF = 16;
  localparam int unsigned SIZE_CLASSES_DEF     = 7;

  // Fixed field widths of the request and response beats
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned STAT_W  = 3;

  // Class size registers
  localparam int unsigned NUM_CFG   = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SIZE_W-1:0] CFG_RESET [NUM_CFG] = '{
    16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd512
  };

  // Request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd4;

  typedef enum logic [1:0] {
    SCPA_INIT,
    SCPA_IDLE,
    SCPA_EXEC
  } scpa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic init_wr;  // write one entry of the list build pass
    logic lookup;   // accept a request beat, read heads and link memory
    logic commit;   // apply the update and load the response register
  } scpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_last;    // last entry of the build pass is being written
    logic out_blocked;  // response register full and not taken
  } scpa_sts_t;

endpackage

[hw/rtl/scpa_if.sv]
// Channel interfaces of the size class pool allocator: request, response, config.
// Depends on scpa_pkg for field widths.
interface scpa_req_if;
  import scpa_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [SIZE_W-1:0]  request_size;
  logic [CLASS_W-1:0] free_class;
  logic [INDEX_W-1:0] free_index;

  modport source (output valid, command, request_size, free_class, free_index, input ready);
  modport sink   (input valid, command, request_size, free_class, free_index, output ready);
endinterface

interface scpa_rsp_if;
  import scpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CLASS_W-1:0] block_class;
  logic [INDEX_W-1:0] block_index;

  modport source (output valid, status, block_class, block_index, input ready);
  modport sink   (input valid, status, block_class, block_index, output ready);
endinterface

interface scpa_cfg_if;
  import scpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/scpa_ctrl.sv]
// Sequencing state machine of the allocator: list build, request accept, commit.
// Depends on scpa_pkg for the state enum and the command and status structs.
module scpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  scpa_pkg::scpa_sts_t  sts_i,
  output scpa_pkg::scpa_cmd_t  cmd_o
);
  import scpa_pkg::*;

  scpa_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCPA_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SCPA_INIT: begin
        if (sts_i.init_last) state_d = SCPA_IDLE;
      end
      SCPA_IDLE: begin
        if (req_valid_i) state_d = SCPA_EXEC;
      end
      SCPA_EXEC: begin
        if (!sts_i.out_blocked) state_d = SCPA_IDLE;
      end
      default: state_d = SCPA_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      SCPA_INIT: begin
        cmd_o.init_wr = 1'b1;
      end
      SCPA_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.lookup = req_valid_i;
      end
      SCPA_EXEC: begin
        cmd_o.commit = !sts_i.out_blocked;
      end
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/scpa_dp.sv]
// Datapath of the allocator: class size registers, list heads, link memory,
// class match and response register. Depends on scpa_pkg.
module scpa_dp #(
  parameter int unsigned BLOCKS_PER_CLASS = scpa_pkg::BLOCKS_PER_CLASS_DEF,
  parameter int unsigned SIZE_CLASSES     = scpa_pkg::SIZE_CLASSES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  scpa_pkg::scpa_cmd_t             cmd_i,
  output scpa_pkg::scpa_sts_t             sts_o,
  input  logic                            req_command_i,
  input  logic [scpa_pkg::SIZE_W-1:0]     req_size_i,
  input  logic [scpa_pkg::CLASS_W-1:0]    req_free_class_i,
  input  logic [scpa_pkg::INDEX_W-1:0]    req_free_index_i,
  input  logic                            cfg_we_i,
  input  logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scpa_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [scpa_pkg::STAT_W-1:0]     rsp_status_o,
  output logic [scpa_pkg::CLASS_W-1:0]    rsp_class_o,
  output logic [scpa_pkg::INDEX_W-1:0]    rsp_index_o
);
  import scpa_pkg::*;

  localparam int unsigned TOTAL  = SIZE_CLASSES * BLOCKS_PER_CLASS;
  localparam int unsigned IDX_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam int unsigned SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned HCLS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  // Link entry: {in_use, link_valid, link}
  localparam int unsigned ENT_W  = IDX_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCKS_PER_CLASS - 1);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [CLASS_W-1:0] cls,
                                               input logic [IDX_W-1:0]   idx);
    slot_of = SLOT_W'(SLOT_W'(cls) * SLOT_W'(BLOCKS_PER_CLASS)) + SLOT_W'(idx);
  endfunction

  logic [SIZE_W-1:0]  cfg_q      [NUM_CFG];
  logic [IDX_W-1:0]   head_idx_q [SIZE_CLASSES];
  logic               head_vld_q [SIZE_CLASSES];
  logic [ENT_W-1:0]   mem_q      [TOTAL];

  logic [CLASS_W-1:0] init_cls_q;
  logic [IDX_W-1:0]   init_idx_q;

  logic               op_q, fit_q, hvld_q, frng_q;
  logic [CLASS_W-1:0] cls_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [ENT_W-1:0]   rd_q;

  logic               rsp_valid_q;
  logic [STAT_W-1:0]  rsp_status_q;
  logic [CLASS_W-1:0] rsp_class_q;
  logic [INDEX_W-1:0] rsp_index_q;

  // Class match: first class whose block size covers the request
  logic               fit;
  logic [CLASS_W-1:0] sel;
  always_comb begin
    fit = 1'b0;
    sel = '0;
    for (int c = int'(SIZE_CLASSES) - 1; c >= 0; c--) begin
      if (req_size_i <= cfg_q[c]) begin
        fit = 1'b1;
        sel = CLASS_W'(c);
      end
    end
  end

  // Lookup: pick class and index, form the link memory address
  logic               frng;
  logic [CLASS_W-1:0] lk_cls;
  logic [IDX_W-1:0]   lk_idx;
  logic [SLOT_W-1:0]  lk_slot;
  always_comb begin
    frng = (32'(req_free_class_i) < SIZE_CLASSES) &&
           (32'(req_free_index_i) < BLOCKS_PER_CLASS);
    if (req_command_i == CMD_ALLOC) begin
      lk_cls = sel;
      lk_idx = head_idx_q[sel[HCLS_W-1:0]];
    end else if (frng) begin
      lk_cls = req_free_class_i;
      lk_idx = IDX_W'(req_free_index_i);
    end else begin
      lk_cls = '0;
      lk_idx = '0;
    end
    lk_slot = slot_of(lk_cls, lk_idx);
  end

  // Hold the request decode for the commit cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      op_q   <= req_command_i;
      fit_q  <= fit;
      hvld_q <= head_vld_q[sel[HCLS_W-1:0]];
      frng_q <= frng;
      cls_q  <= lk_cls;
      idx_q  <= lk_idx;
      slot_q <= lk_slot;
    end
  end

  // Commit: decide the outcome from the fetched link entry
  logic               e_use, e_lv;
  logic [IDX_W-1:0]   e_link;
  logic               do_alloc, do_free;
  logic [STAT_W-1:0]  ex_status;
  logic [ENT_W-1:0]   ex_wdata;
  logic [HCLS_W-1:0]  cls_h;
  always_comb begin
    e_use    = rd_q[ENT_W-1];
    e_lv     = rd_q[IDX_W];
    e_link   = rd_q[IDX_W-1:0];
    cls_h    = cls_q[HCLS_W-1:0];
    do_alloc = 1'b0;
    do_free  = 1'b0;
    ex_wdata = rd_q;
    if (op_q == CMD_ALLOC) begin
      if (!fit_q) begin
        ex_status = ST_TOO_LARGE;
      end else if (!hvld_q) begin
        ex_status = ST_EMPTY;
      end else begin
        ex_status = ST_ALLOCATED;
        do_alloc  = 1'b1;
        ex_wdata  = {1'b1, e_lv, e_link};
      end
    end else begin
      if (!frng_q || !e_use) begin
        ex_status = ST_REJECTED;
      end else begin
        ex_status = ST_FREED;
        do_free   = 1'b1;
        ex_wdata  = {1'b0, head_vld_q[cls_h], head_idx_q[cls_h]};
      end
    end
  end

  // Link memory write: build pass or commit
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  always_comb begin
    if (cmd_i.init_wr) begin
      mem_we    = 1'b1;
      mem_waddr = slot_of(init_cls_q, init_idx_q);
      mem_wdata = {1'b0, (init_idx_q != '0), IDX_W'(init_idx_q - 1'b1)};
    end else begin
      mem_we    = cmd_i.commit && (do_alloc || do_free);
      mem_waddr = slot_q;
      mem_wdata = ex_wdata;
    end
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.lookup) rd_q <= mem_q[lk_slot];
  end

  // Build pass counters: every class, every index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cls_q <= '0;
      init_idx_q <= '0;
    end else if (cmd_i.init_wr) begin
      if (init_idx_q == LAST_IDX) begin
        init_idx_q <= '0;
        init_cls_q <= init_cls_q + 1'b1;
      end else begin
        init_idx_q <= init_idx_q + 1'b1;
      end
    end
  end

  // Class size registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(NUM_CFG); r++) cfg_q[r] <= CFG_RESET[r];
    end else if (cfg_we_i && (32'(cfg_index_i) < NUM_CFG)) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // List heads: pop on allocate, push on free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < int'(SIZE_CLASSES); c++) begin
        head_idx_q[c] <= LAST_IDX;
        head_vld_q[c] <= 1'b1;
      end
    end else if (cmd_i.commit) begin
      if (do_alloc) begin
        head_idx_q[cls_h] <= e_link;
        head_vld_q[cls_h] <= e_lv;
      end else if (do_free) begin
        head_idx_q[cls_h] <= idx_q;
        head_vld_q[cls_h] <= 1'b1;
      end
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_status_q <= ex_status;
      rsp_class_q  <= do_alloc ? cls_q : '0;
      rsp_index_q  <= do_alloc ? INDEX_W'(idx_q) : '0;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_class_o  = rsp_class_q;
  assign rsp_index_o  = rsp_index_q;

  assign sts_o.init_last   = cmd_i.init_wr &&
                             (32'(init_cls_q) == SIZE_CLASSES - 1) &&
                             (init_idx_q == LAST_IDX);
  assign sts_o.out_blocked = rsp_valid_q && !rsp_ready_i;

endmodule

[hw/rtl/size_class_pool_allocator.sv]
// Top level of the size class pool allocator: controller, datapath, channels.
// Depends on scpa_pkg, scpa_if, scpa_ctrl and scpa_dp.
//
//   channel  dir  fields                                         beat when
//   req_i    in   command, request_size, free_class, free_index  valid && ready
//   rsp_o    out  status, block_class, block_index                valid && ready
//   cfg_i    in   index, data (class size register)               valid && ready
//
// On acceptance a request reads the list head and the link memory entry; in the
// commit state both are written back and the response register is loaded.
// After reset a build pass writes every link memory entry, one per cycle, before
// the first request is taken.
// A full response register that is not taken holds the commit cycle; a new
// request is still accepted while a finished response waits.
// Config writes are taken every cycle.
module size_class_pool_allocator #(
  parameter int unsigned BLOCKS_PER_CLASS = scpa_pkg::BLOCKS_PER_CLASS_DEF,
  parameter int unsigned SIZE_CLASSES     = scpa_pkg::SIZE_CLASSES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  scpa_req_if.sink          req_i,
  scpa_rsp_if.source        rsp_o,
  scpa_cfg_if.sink          cfg_i
);
  import scpa_pkg::*;

  scpa_cmd_t cmd;
  scpa_sts_t sts;

  assign cfg_i.ready = 1'b1;

  scpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scpa_dp #(
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
    .SIZE_CLASSES     (SIZE_CLASSES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_command_i    (req_i.command),
    .req_size_i       (req_i.request_size),
    .req_free_class_i (req_i.free_class),
    .req_free_index_i (req_i.free_index),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_status_o     (rsp_o.status),
    .rsp_class_o      (rsp_o.block_class),
    .rsp_index_o      (rsp_o.block_index)
  );

  // An accepted request leaves the channel closed for the commit cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted during commit");

  // A commit always lands in the response register
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("commit without response");

  // Never overwrite a waiting response
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("response overwritten");

  // Only a granted block carries a handle, and only in a configured class
  a_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.status == ST_ALLOCATED && 32'(rsp_o.block_class) < SIZE_CLASSES)
                  || (rsp_o.block_class == '0 && rsp_o.block_index == '0)))
    else $error("bad response handle");

endmodule
